### src/kpe_pkg.sv
// Shared types and constants of the keyboard pointer emulator.
// Word structs of both channels, opcode, key, action and register codes.
// No dependencies.
package kpe_pkg;

  // Field widths fixed by the word formats
  localparam int POS_W      = 13;
  localparam int SCREEN_W   = 13;
  localparam int STEP_W     = 16;
  localparam int RAMP_W     = 12;
  localparam int HOLD_W     = 12;
  localparam int DZ_W       = 8;
  localparam int LINES_W    = 7;
  localparam int SCROLL_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Serial ramp unit: product register and step counter
  localparam int MUL_W  = STEP_W + RAMP_W;
  localparam int CNT_W  = 4;
  localparam int DIAG_W = STEP_W + 8;
  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
  localparam logic [DIAG_W-1:0] DIAG_NUM = DIAG_W'(181);

  // Opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_KEY  = 2'd1;
  localparam logic [1:0] OP_SYNC = 2'd2;

  // Key codes
  localparam logic [3:0] KEY_SPACE     = 4'd1;
  localparam logic [3:0] KEY_ESCAPE    = 4'd2;
  localparam logic [3:0] KEY_UP        = 4'd3;
  localparam logic [3:0] KEY_RIGHT     = 4'd6;
  localparam logic [3:0] KEY_LEFT_BTN  = 4'd7;
  localparam logic [3:0] KEY_RIGHT_BTN = 4'd8;
  localparam logic [3:0] KEY_SCROLL_UP = 4'd9;
  localparam logic [3:0] KEY_SCROLL_DN = 4'd10;

  // Action codes
  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_PASS     = 4'd1;
  localparam logic [3:0] ACT_SWALLOW  = 4'd2;
  localparam logic [3:0] ACT_MOVE     = 4'd3;
  localparam logic [3:0] ACT_DRAG     = 4'd4;
  localparam logic [3:0] ACT_LDOWN    = 4'd5;
  localparam logic [3:0] ACT_LUP      = 4'd6;
  localparam logic [3:0] ACT_RDOWN    = 4'd7;
  localparam logic [3:0] ACT_RUP      = 4'd8;
  localparam logic [3:0] ACT_SCROLL   = 4'd9;
  localparam logic [3:0] ACT_QUIT     = 4'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TICKS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_LINES  = 3'd6;

  typedef struct packed {
    logic [1:0]       op;
    logic [3:0]       key_id;
    logic             key_down;
    logic             alt_held;
    logic [POS_W-1:0] pointer_x;
    logic [POS_W-1:0] pointer_y;
  } in_word_t;

  typedef struct packed {
    logic [3:0]                 action;
    logic [POS_W-1:0]           pos_x;
    logic [POS_W-1:0]           pos_y;
    logic signed [SCROLL_W-1:0] scroll_amount;
    logic                       intercepting;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV,
    S_SUM,
    S_DIAG,
    S_MOVE_X,
    S_MOVE_Y,
    S_FINISH
  } state_t;

endpackage

### src/keyboard_pointer_emulator_core.sv
// Keyboard pointer emulator: key events and frame ticks in, pointer actions out.
// Depends on kpe_pkg.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid / in_stall  | in_data  (op, key, pointer)
//   out     | output    | out_valid / out_stall| out_data (action, position)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word at a time. A key, sync, idle tick or deadzone tick holds the input
// through the decode and finish states; a moving tick past the ramp (step at max)
// also through the diagonal and move states; one inside the ramp first through
// the bit-serial multiply (12 steps) and the restoring divide (16 steps).
// The output register takes the next result while the previous one is stalled
// only after it drains. Reset (rst, synchronous) loads the register defaults
// and clears the position, hold count, direction flags and modes.
module keyboard_pointer_emulator_core
  import kpe_pkg::*;
#(
  parameter int FRAC_BITS  = 8,
  parameter int COORD_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int P_W = COORD_BITS + FRAC_BITS;
  localparam int EW  = ((P_W > STEP_W) ? P_W : STEP_W) + 2;
  localparam int LW  = (COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  // Configuration registers
  logic [SCREEN_W-1:0] screen_width, screen_height;
  logic [STEP_W-1:0]   start_step, max_step;
  logic [RAMP_W-1:0]   ramp_ticks;
  logic [DZ_W-1:0]     deadzone_ticks;
  logic [LINES_W-1:0]  scroll_lines;

  // Architectural state
  logic [P_W-1:0]    position_x, position_y;
  logic [HOLD_W-1:0] hold_count;
  logic [3:0]        direction_flags;
  logic              dragging;
  logic              intercept_on;

  // Sequencer and datapath registers
  state_t                     state, state_next;
  in_word_t                   item;
  logic [MUL_W-1:0]           prod;
  logic [CNT_W-1:0]           cnt;
  logic [STEP_W-1:0]          step;
  logic [3:0]                 act;
  logic signed [SCROLL_W-1:0] scroll;

  // Combinational decode
  logic              dx_pos, dx_neg, dy_pos, dy_neg, moving, diagonal;
  logic [HOLD_W-1:0] hold_inc, ramp_t;
  logic              in_dead, use_max, tick_moves, out_free, descending;
  logic [STEP_W-1:0] diff;
  logic [STEP_W:0]   mul_sum;
  logic [RAMP_W:0]   trial;
  logic              quot_bit;
  logic [RAMP_W-1:0] rem_next;
  logic [DIAG_W-1:0] diag_prod;
  logic [3:0]        key_off, flag_bit;
  logic [SCROLL_W-1:0] lines_ext;

  // Move datapath
  logic                  axis_y, dir_up, dir_dn;
  logic [P_W-1:0]        pos_cur, hi, pos_new;
  logic [SCREEN_W-1:0]   scr;
  logic [LW-1:0]         scr_ext, cmax_ext;
  logic [COORD_BITS-1:0] lim;
  logic [EW-1:0]         pos_ext, step_ext, hi_ext, v;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // Net direction and hold timing
  always_comb begin
    dx_pos     = direction_flags[3] & ~direction_flags[2];
    dx_neg     = direction_flags[2] & ~direction_flags[3];
    dy_pos     = direction_flags[1] & ~direction_flags[0];
    dy_neg     = direction_flags[0] & ~direction_flags[1];
    moving     = dx_pos | dx_neg | dy_pos | dy_neg;
    diagonal   = (dx_pos | dx_neg) & (dy_pos | dy_neg);
    hold_inc   = (hold_count == HOLD_MAX) ? hold_count : hold_count + HOLD_W'(1);
    in_dead    = hold_inc < HOLD_W'(deadzone_ticks);
    ramp_t     = hold_inc - HOLD_W'(deadzone_ticks);
    use_max    = (ramp_ticks == '0) || (ramp_t >= ramp_ticks);
    tick_moves = (item.op == OP_TICK) && intercept_on && moving && !in_dead;
    descending = max_step < start_step;
    diff       = descending ? (start_step - max_step) : (max_step - start_step);
    out_free   = !out_valid || !out_stall;
    key_off    = item.key_id - KEY_UP;
    flag_bit   = 4'b0001 << key_off[1:0];
    lines_ext  = SCROLL_W'(scroll_lines);
  end

  // Serial multiply and divide steps
  always_comb begin
    mul_sum   = {1'b0, prod[MUL_W-1:RAMP_W]} + (prod[0] ? {1'b0, diff} : '0);
    trial     = {prod[MUL_W-1:STEP_W], prod[STEP_W-1]};
    quot_bit  = trial >= {1'b0, ramp_ticks};
    rem_next  = quot_bit ? RAMP_W'(trial - {1'b0, ramp_ticks}) : trial[RAMP_W-1:0];
    diag_prod = DIAG_W'(step) * DIAG_NUM;
  end

  // Move one axis and clamp to the screen
  always_comb begin
    axis_y   = (state == S_MOVE_Y);
    pos_cur  = axis_y ? position_y : position_x;
    dir_up   = axis_y ? dy_pos : dx_pos;
    dir_dn   = axis_y ? dy_neg : dx_neg;
    scr      = axis_y ? screen_height : screen_width;
    scr_ext  = LW'(scr);
    cmax_ext = LW'(COORD_MAX);
    lim      = COORD_BITS'((scr_ext > cmax_ext) ? cmax_ext : scr_ext);
    hi       = {lim, {FRAC_BITS{1'b0}}};
    pos_ext  = EW'(pos_cur);
    step_ext = EW'(step);
    hi_ext   = EW'(hi);
    if (dir_up) begin
      v = pos_ext + step_ext;
    end else if (dir_dn) begin
      v = pos_ext - step_ext;
    end else begin
      v = pos_ext;
    end
    if (v[EW-1]) begin
      pos_new = '0;
    end else if (v > hi_ext) begin
      pos_new = hi;
    end else begin
      pos_new = P_W'(v);
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (tick_moves) begin
          state_next = use_max ? S_DIAG : S_MUL;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MUL: begin
        if (cnt == '0) state_next = S_DIV;
      end
      S_DIV: begin
        if (cnt == '0) state_next = S_SUM;
      end
      S_SUM:    state_next = S_DIAG;
      S_DIAG:   state_next = S_MOVE_X;
      S_MOVE_X: state_next = S_MOVE_Y;
      S_MOVE_Y: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width   <= SCREEN_W'(1920);
      screen_height  <= SCREEN_W'(1080);
      start_step     <= STEP_W'(85);
      max_step       <= STEP_W'(4267);
      ramp_ticks     <= RAMP_W'(42);
      deadzone_ticks <= DZ_W'(3);
      scroll_lines   <= LINES_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width   <= cfg_data[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: screen_height  <= cfg_data[SCREEN_W-1:0];
        REG_START_STEP:    start_step     <= cfg_data[STEP_W-1:0];
        REG_MAX_STEP:      max_step       <= cfg_data[STEP_W-1:0];
        REG_RAMP_TICKS:    ramp_ticks     <= cfg_data[RAMP_W-1:0];
        REG_DEADZONE:      deadzone_ticks <= cfg_data[DZ_W-1:0];
        REG_SCROLL_LINES:  scroll_lines   <= cfg_data[LINES_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the input word
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) item <= in_data;
  end

  // Pointer state and ramp datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x      <= '0;
      position_y      <= '0;
      hold_count      <= '0;
      direction_flags <= '0;
      dragging        <= 1'b0;
      intercept_on    <= 1'b0;
    end else begin
      case (state)
        S_DECODE: begin
          act    <= ACT_NONE;
          scroll <= '0;
          case (item.op)
            OP_TICK: begin
              if (intercept_on) begin
                if (!moving) begin
                  hold_count <= '0;
                end else begin
                  hold_count <= hold_inc;
                  if (!in_dead) begin
                    act  <= dragging ? ACT_DRAG : ACT_MOVE;
                    step <= max_step;
                    prod <= {STEP_W'(0), ramp_t};
                    cnt  <= CNT_W'(RAMP_W - 1);
                  end
                end
              end
            end
            OP_KEY: begin
              if (item.key_id == KEY_SPACE && item.alt_held) begin
                if (item.key_down) intercept_on <= !intercept_on;
                act <= ACT_SWALLOW;
              end else if (item.key_id == KEY_ESCAPE && item.alt_held) begin
                act <= item.key_down ? ACT_QUIT : ACT_SWALLOW;
              end else if (!intercept_on) begin
                act <= ACT_PASS;
              end else if (item.key_id inside {[KEY_UP:KEY_RIGHT]}) begin
                direction_flags <= item.key_down ? (direction_flags | flag_bit)
                                                 : (direction_flags & ~flag_bit);
                act <= ACT_SWALLOW;
              end else begin
                case (item.key_id)
                  KEY_LEFT_BTN: begin
                    dragging <= item.key_down;
                    act      <= item.key_down ? ACT_LDOWN : ACT_LUP;
                  end
                  KEY_RIGHT_BTN: begin
                    act <= item.key_down ? ACT_RDOWN : ACT_RUP;
                  end
                  KEY_SCROLL_UP: begin
                    act <= item.key_down ? ACT_SCROLL : ACT_SWALLOW;
                    if (item.key_down) scroll <= lines_ext;
                  end
                  KEY_SCROLL_DN: begin
                    act <= item.key_down ? ACT_SCROLL : ACT_SWALLOW;
                    if (item.key_down) scroll <= SCROLL_W'(0) - lines_ext;
                  end
                  default: act <= ACT_PASS;
                endcase
              end
            end
            OP_SYNC: begin
              position_x <= {COORD_BITS'(item.pointer_x), {FRAC_BITS{1'b0}}};
              position_y <= {COORD_BITS'(item.pointer_y), {FRAC_BITS{1'b0}}};
              act        <= ACT_PASS;
            end
            default: act <= ACT_NONE;
          endcase
        end
        // Shift-add: one multiplier bit of the ramp time per cycle
        S_MUL: begin
          prod <= {mul_sum, prod[RAMP_W-1:1]};
          cnt  <= (cnt == '0) ? CNT_W'(STEP_W - 1) : cnt - CNT_W'(1);
        end
        // Restoring divide by ramp_ticks: one quotient bit per cycle
        S_DIV: begin
          prod <= {rem_next, prod[STEP_W-2:0], quot_bit};
          cnt  <= cnt - CNT_W'(1);
        end
        S_SUM: begin
          step <= descending ? (start_step - prod[STEP_W-1:0])
                             : (start_step + prod[STEP_W-1:0]);
        end
        S_DIAG: begin
          if (diagonal) step <= diag_prod[DIAG_W-1:8];
        end
        S_MOVE_X: position_x <= pos_new;
        S_MOVE_Y: position_y <= pos_new;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      out_data.action        <= act;
      out_data.pos_x         <= POS_W'(position_x[P_W-1:FRAC_BITS]);
      out_data.pos_y         <= POS_W'(position_y[P_W-1:FRAC_BITS]);
      out_data.scroll_amount <= scroll;
      out_data.intercepting  <= intercept_on;
    end
  end

endmodule

### src/kpe_checker.sv
// Port-level checks of the keyboard pointer emulator, bound to its top level.
// Depends on kpe_pkg and keyboard_pointer_emulator_core.
module kpe_checker
  import kpe_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // One word in flight: the input closes right after a word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted a second word back to back");

  // A result never shows up in the cycle after its word was taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after acceptance");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // Scroll amount only travels with a scroll action
  a_scroll_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.action != ACT_SCROLL |-> out_data.scroll_amount == '0)
    else $error("scroll amount on a non-scroll action");

  // Pointer motion only while interception is on
  a_move_intercept: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.action == ACT_MOVE || out_data.action == ACT_DRAG)
      |-> out_data.intercepting)
    else $error("move or drag reported with interception off");

endmodule

bind keyboard_pointer_emulator_core kpe_checker u_kpe_checker (.*);

### test/keyboard_pointer_emulator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for keyboard_pointer_emulator_core: a queued driver, a checking
// monitor and an in-bench model of the pointer emulator, run over several register settings.
// Depends on kpe_pkg and the core.
module keyboard_pointer_emulator_core_tb;
  import kpe_pkg::*;

  localparam int FRAC         = 8;
  localparam int DIAG_SCALE   = 181;
  localparam int CYCLE_LIMIT  = 1200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_LEN     = 300;
  localparam int PHASE_ITEMS  = 300;
  localparam int LONG_TICKS   = 300;

  // Codes the package leaves out
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [3:0] KEY_OTHER = 4'd0;
  localparam logic [3:0] KEY_DOWN  = 4'd4;
  localparam logic [3:0] KEY_LEFT  = 4'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  keyboard_pointer_emulator_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Register copies
  logic [SCREEN_W-1:0] scr_w, scr_h;
  logic [STEP_W-1:0]   step_lo, step_hi;
  logic [RAMP_W-1:0]   ramp_len;
  logic [DZ_W-1:0]     dz_len;
  logic [LINES_W-1:0]  lines_per;

  // Emulator state as the bench sees it
  longint            pos_x_fx, pos_y_fx;
  logic [HOLD_W-1:0] hold_ticks;
  logic [3:0]        dir_held;
  logic              drag_on, icpt_on;

  in_word_t  event_q[$];
  out_word_t action_q[$];

  int  send_wait = 0, send_calm = 0, recv_wait = 0, recv_calm = 0;
  int  items_sent = 0, cycle_count = 0, err_count = 0, hold_cycles = 0;
  logic hold_done = 1'b0;
  bit  idle_on = 1'b1;
  bit  gen_icpt = 1'b0;
  int  gen_pushed = 0;
  wire long_hold = (hold_cycles != 0);

  function automatic longint ramp_step(longint t);
    longint s, m;
    s = longint'(step_lo);
    m = longint'(step_hi);
    if (ramp_len == 0 || t >= longint'(ramp_len)) return m;
    if (m >= s) return s + (m - s) * t / longint'(ramp_len);
    return s - (s - m) * t / longint'(ramp_len);
  endfunction

  function automatic longint clamp_fx(longint v, logic [SCREEN_W-1:0] limit);
    longint hi;
    hi = longint'(limit) <<< FRAC;
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Work out the action of one word and advance the state
  function automatic out_word_t predict_action(in_word_t w);
    out_word_t r;
    logic [3:0] act;
    longint step, dx, dy;
    int scroll;
    act = ACT_NONE;
    scroll = 0;
    case (w.op)
      OP_TICK: if (icpt_on) begin
        dx = longint'(dir_held[3]) - longint'(dir_held[2]);
        dy = longint'(dir_held[1]) - longint'(dir_held[0]);
        if (dx == 0 && dy == 0) begin
          hold_ticks = '0;
        end else begin
          if (hold_ticks != HOLD_MAX) hold_ticks = hold_ticks + 1'b1;
          if (hold_ticks >= dz_len) begin
            step = ramp_step(longint'(hold_ticks) - longint'(dz_len));
            if (dx != 0 && dy != 0) step = (step * DIAG_SCALE) >>> 8;
            pos_x_fx = clamp_fx(pos_x_fx + dx * step, scr_w);
            pos_y_fx = clamp_fx(pos_y_fx + dy * step, scr_h);
            act = drag_on ? ACT_DRAG : ACT_MOVE;
          end
        end
      end
      OP_KEY: begin
        if (w.key_id == KEY_SPACE && w.alt_held) begin
          if (w.key_down) icpt_on = !icpt_on;
          act = ACT_SWALLOW;
        end else if (w.key_id == KEY_ESCAPE && w.alt_held) begin
          act = w.key_down ? ACT_QUIT : ACT_SWALLOW;
        end else if (!icpt_on) begin
          act = ACT_PASS;
        end else begin
          case (w.key_id)
            KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT: begin
              dir_held[2'(w.key_id - KEY_UP)] = w.key_down;
              act = ACT_SWALLOW;
            end
            KEY_LEFT_BTN: begin
              drag_on = w.key_down;
              act = w.key_down ? ACT_LDOWN : ACT_LUP;
            end
            KEY_RIGHT_BTN: act = w.key_down ? ACT_RDOWN : ACT_RUP;
            KEY_SCROLL_UP, KEY_SCROLL_DN: begin
              if (!w.key_down) begin
                act = ACT_SWALLOW;
              end else begin
                scroll = (w.key_id == KEY_SCROLL_UP) ? int'(lines_per) : -int'(lines_per);
                act = ACT_SCROLL;
              end
            end
            default: act = ACT_PASS;
          endcase
        end
      end
      OP_SYNC: begin
        pos_x_fx = longint'(w.pointer_x) <<< FRAC;
        pos_y_fx = longint'(w.pointer_y) <<< FRAC;
        act = ACT_PASS;
      end
      default: act = ACT_NONE;
    endcase
    r.action        = act;
    r.pos_x         = POS_W'(pos_x_fx >>> FRAC);
    r.pos_y         = POS_W'(pos_y_fx >>> FRAC);
    r.scroll_amount = SCROLL_W'(scroll);
    r.intercepting  = icpt_on;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  // Wait per word, with calm stretches of no waiting
  function automatic int draw_wait(inout int calm);
    if (!idle_on) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 16)) : 0;
  endfunction

  // Driver: offer queued words, predict each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        action_q.push_back(predict_action(in_data));
        items_sent <= items_sent + 1;
        send_wait = draw_wait(send_calm);
      end
      if (!in_valid || !in_stall) begin
        if (send_wait == 0 && event_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= event_q.pop_front();
        end else begin
          in_valid <= 1'b0;
          if (send_wait > 0) send_wait--;
        end
      end
    end
  end

  // Monitor: check each accepted word against the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (action_q.size() == 0) begin
          report_mismatch("unexpected word, action", out_data.action, -1);
        end else begin
          want = action_q.pop_front();
          if (out_data.action !== want.action)
            report_mismatch("action", out_data.action, want.action);
          if (out_data.pos_x !== want.pos_x)
            report_mismatch("pos_x", out_data.pos_x, want.pos_x);
          if (out_data.pos_y !== want.pos_y)
            report_mismatch("pos_y", out_data.pos_y, want.pos_y);
          if (out_data.scroll_amount !== want.scroll_amount)
            report_mismatch("scroll_amount", out_data.scroll_amount, want.scroll_amount);
          if (out_data.intercepting !== want.intercepting)
            report_mismatch("intercepting", out_data.intercepting, want.intercepting);
        end
        recv_wait = draw_wait(recv_calm);
      end else if (out_valid && recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= long_hold || recv_wait > 0;
    end
  end

  // Long hold-off on the output once, so the core backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && items_sent >= HOLD_AT) begin
      hold_cycles <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = SCREEN_W'(value);
      REG_SCREEN_HEIGHT: scr_h = SCREEN_W'(value);
      REG_START_STEP:    step_lo = STEP_W'(value);
      REG_MAX_STEP:      step_hi = STEP_W'(value);
      REG_RAMP_TICKS:    ramp_len = RAMP_W'(value);
      REG_DEADZONE:      dz_len = DZ_W'(value);
      REG_SCROLL_LINES:  lines_per = LINES_W'(value);
      default: ;
    endcase
  endtask

  // Hold valid across back-to-back writes; the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
  endtask

  task automatic write_settings(int unsigned w, int unsigned h, int unsigned lo, int unsigned hi,
                                int unsigned ramp, int unsigned dz, int unsigned lines);
    @(posedge clk);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_START_STEP, lo);
    write_reg(REG_MAX_STEP, hi);
    write_reg(REG_RAMP_TICKS, ramp);
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_SCROLL_LINES, lines);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (event_q.size() != 0 || in_valid || action_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic in_word_t noise_word();
    in_word_t w;
    w.op        = 2'($urandom_range(0, 3));
    w.key_id    = 4'($urandom_range(0, 15));
    w.key_down  = 1'($urandom_range(0, 1));
    w.alt_held  = 1'($urandom_range(0, 1));
    w.pointer_x = POS_W'($urandom_range(0, 8191));
    w.pointer_y = POS_W'($urandom_range(0, 8191));
    return w;
  endfunction

  // Queue a word, tracking the interception toggle it may cause
  task automatic push_word(in_word_t w);
    if (w.op == OP_KEY && w.key_id == KEY_SPACE && w.alt_held && w.key_down)
      gen_icpt = !gen_icpt;
    event_q.push_back(w);
    gen_pushed++;
  endtask

  task automatic push_key(logic [3:0] key, logic down, logic alt);
    in_word_t w;
    w = noise_word();
    w.op = OP_KEY;
    w.key_id = key;
    w.key_down = down;
    w.alt_held = alt;
    push_word(w);
  endtask

  task automatic push_op(logic [1:0] op);
    in_word_t w;
    w = noise_word();
    w.op = op;
    push_word(w);
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_op(OP_TICK);
  endtask

  task automatic push_sync(int x, int y);
    in_word_t w;
    w = noise_word();
    w.op = OP_SYNC;
    w.pointer_x = POS_W'(x);
    w.pointer_y = POS_W'(y);
    push_word(w);
  endtask

  task automatic push_toggle();
    push_key(KEY_SPACE, 1'b1, 1'b1);
    push_key(KEY_SPACE, 1'b0, 1'b1);
  endtask

  // One well-formed stretch of use with random content
  task automatic gen_session(int reach);
    int kind, n, i;
    logic [3:0] dirs;
    logic drag;
    kind = $urandom_range(0, 9);
    if (!gen_icpt && kind != 9) push_toggle();
    if (kind <= 5) begin
      dirs = 4'($urandom_range(1, 15));
      drag = ($urandom_range(0, 3) == 0);
      if (drag) push_key(KEY_LEFT_BTN, 1'b1, 1'b0);
      for (i = 0; i < 4; i++)
        if (dirs[2'(i)]) push_key(4'(KEY_UP + i), 1'b1, 1'($urandom_range(0, 1)));
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, reach) : $urandom_range(1, 12);
      push_ticks(n);
      if ($urandom_range(0, 2) == 0) begin
        push_sync($urandom_range(0, 8191), $urandom_range(0, 8191));
        push_ticks($urandom_range(1, 8));
      end
      for (i = 0; i < 4; i++)
        if (dirs[2'(i)] && $urandom_range(0, 4) != 0) push_key(4'(KEY_UP + i), 1'b0, 1'b0);
      if (drag) push_key(KEY_LEFT_BTN, 1'b0, 1'b0);
      push_ticks($urandom_range(0, 2));
    end else if (kind == 6) begin
      repeat ($urandom_range(2, 6))
        push_key(4'($urandom_range(KEY_LEFT_BTN, KEY_SCROLL_DN)), 1'($urandom_range(0, 1)),
                 1'b0);
    end else if (kind == 7) begin
      push_sync($urandom_range(0, 8191), $urandom_range(0, 8191));
      push_ticks($urandom_range(1, 6));
    end else if (kind == 8) begin
      // drop interception and poke keys that must pass untouched
      push_toggle();
      repeat ($urandom_range(2, 6)) begin
        push_key(4'($urandom_range(KEY_OTHER, 15)), 1'($urandom_range(0, 1)), 1'b0);
        push_ticks($urandom_range(0, 2));
      end
    end else begin
      push_key(KEY_ESCAPE, 1'b1, 1'b1);
      push_key(KEY_ESCAPE, 1'b0, 1'b1);
      push_key(KEY_ESCAPE, 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  task automatic run_random(int quota);
    int start, reach, span;
    start = gen_pushed;
    span = (ramp_len > 60) ? 60 : int'(ramp_len);
    reach = int'(dz_len) + span + 10;
    if (reach > 400) reach = 400;
    while (gen_pushed - start < quota) begin
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 6)) push_word(noise_word());
      else
        gen_session(reach);
    end
  endtask

  initial begin
    int i;
    // Power-on register values and cleared state
    scr_w = 13'd1920; scr_h = 13'd1080;
    step_lo = 16'd85; step_hi = 16'd4267;
    ramp_len = 12'd42; dz_len = 8'd3; lines_per = 7'd3;
    pos_x_fx = 0; pos_y_fx = 0;
    hold_ticks = '0; dir_held = '0;
    drag_on = 1'b0; icpt_on = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words on the power-on settings
    push_op(OP_TICK);                        // tick with interception off
    push_key(KEY_UP, 1'b1, 1'b0);            // key passes while off
    push_key(KEY_ESCAPE, 1'b1, 1'b1);        // quit
    push_key(KEY_ESCAPE, 1'b0, 1'b1);        // swallowed release
    push_sync(8191, 8191);                   // sync beyond the screen, unclamped
    push_toggle();
    push_op(OP_TICK);                        // no direction held
    push_key(KEY_OTHER, 1'b1, 1'b0);
    push_key(4'd15, 1'b1, 1'b1);             // unknown key passes
    push_key(KEY_RIGHT, 1'b1, 1'b0);
    push_key(KEY_LEFT, 1'b1, 1'b0);
    push_op(OP_TICK);                        // opposite keys cancel
    push_key(KEY_LEFT, 1'b0, 1'b0);
    push_key(KEY_LEFT_BTN, 1'b1, 1'b0);
    push_ticks(3);                           // deadzone, then a clamped drag
    push_key(KEY_UP, 1'b1, 1'b0);
    push_op(OP_TICK);                        // diagonal
    push_key(KEY_LEFT_BTN, 1'b0, 1'b0);
    push_key(KEY_SCROLL_UP, 1'b1, 1'b0);
    push_key(KEY_SCROLL_DN, 1'b1, 1'b0);
    push_key(KEY_SCROLL_UP, 1'b0, 1'b0);
    push_key(KEY_RIGHT_BTN, 1'b1, 1'b0);
    push_op(OP_UNUSED);
    wait_idle();

    // Moderate random settings
    write_settings($urandom_range(100, 4000), $urandom_range(100, 3000), $urandom_range(0, 2000),
                   $urandom_range(0, 8000), $urandom_range(1, 100), $urandom_range(0, 10),
                   $urandom_range(1, 127));
    run_random(PHASE_ITEMS);
    wait_idle();

    // Extremes: fastest ramp, flat bottom edge
    write_settings(8191, 0, 0, 65535, 1, 0, 127);
    run_random(PHASE_ITEMS);
    wait_idle();

    // Extremes: falling ramp, longest ramp and deadzone
    write_settings(0, 8191, 65535, 0, 4095, 255, 0);
    run_random(PHASE_ITEMS);
    wait_idle();

    // Zero ramp jumps straight to the maximum step
    write_settings($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), 0, $urandom_range(0, 20), $urandom_range(0, 127));
    run_random(PHASE_ITEMS);
    wait_idle();

    // Hold one diagonal through the deadzone and the whole ramp, no idling
    write_settings(8191, 8191, 0, 4000, 200, 20, 1);
    idle_on = 1'b0;
    if (!gen_icpt) push_toggle();
    push_key(KEY_UP, 1'b0, 1'b0);
    push_key(KEY_LEFT, 1'b0, 1'b0);
    push_key(KEY_RIGHT, 1'b1, 1'b0);
    push_key(KEY_DOWN, 1'b1, 1'b0);
    for (i = 0; i < LONG_TICKS; i++) begin
      if (i % 250 == 0) push_sync(200, 300);
      push_op(OP_TICK);
    end
    push_key(KEY_RIGHT, 1'b0, 1'b0);
    push_key(KEY_DOWN, 1'b0, 1'b0);
    push_op(OP_TICK);

    // Drain and let any stray word show up
    do @(negedge clk); while (event_q.size() != 0 || in_valid || action_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### keyboard_pointer_emulator_core.f
src/kpe_pkg.sv
src/keyboard_pointer_emulator_core.sv
src/kpe_checker.sv
test/keyboard_pointer_emulator_core_tb.sv
